/* rtl/cma_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the confusion matrix accumulator.
// Used by cma_rate_div and confusion_matrix_accumulator; depends on nothing.
package cma_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int CLASS_W     = $clog2(MAX_CLASSES);
    localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;
    localparam int ADDR_W      = 2 * CLASS_W;
    localparam int NCLS_W      = 5;
    localparam int CELL_W      = 48;
    localparam int SUM_W       = 56;
    localparam int WEIGHT_W    = 32;
    localparam int FRAC_W      = 16;
    localparam int RATE_W      = FRAC_W + 1;
    localparam int STEP_W      = $clog2(FRAC_W);
    localparam int STATUS_W    = 3;

    localparam logic [NCLS_W-1:0] NCLS_RESET = NCLS_W'(2);
    localparam logic [NCLS_W-1:0] NCLS_MIN   = NCLS_W'(2);
    localparam logic [NCLS_W-1:0] NCLS_MAX   = NCLS_W'(MAX_CLASSES);

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRED_MISSING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACT_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL   = 3'd4;

    localparam logic [RATE_W-1:0] RATE_ONE  = RATE_W'(1) << FRAC_W;
    localparam logic [RATE_W-1:0] RATE_ZERO = '0;

    typedef struct packed {
        logic                       action;
        logic [CLASS_W-1:0]         actual_class;
        logic [CLASS_W-1:0]         predicted_class;
        logic                       actual_missing;
        logic                       predicted_missing;
        logic signed [WEIGHT_W-1:0] weight;
        logic [CLASS_W-1:0]         query_class;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [SUM_W-1:0] true_pos;
        logic signed [SUM_W-1:0] false_pos;
        logic signed [SUM_W-1:0] true_neg;
        logic signed [SUM_W-1:0] false_neg;
        logic signed [SUM_W-1:0] correct_sum;
        logic signed [SUM_W-1:0] incorrect_sum;
        logic signed [SUM_W-1:0] total_sum;
        logic [RATE_W-1:0]       error_rate;
    } rsp_t;

endpackage

/* rtl/cma_rate_div.sv */
`timescale 1ns / 1ps
// Error rate unit: incorrect / total in unsigned Q1.16, clamped to [0, 1].
// Restoring divider, one quotient bit per cycle; depends on cma_pkg.
module cma_rate_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cma_pkg::SUM_W-1:0]  incorrect_sum,
    input  logic signed [cma_pkg::SUM_W-1:0]  total_sum,
    output logic                              done,
    output logic [cma_pkg::RATE_W-1:0]        rate
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CMP  = 2'd1;
    localparam logic [1:0] D_STEP = 2'd2;

    logic [1:0]                     dstate_reg, dstate_next;
    logic [cma_pkg::SUM_W-1:0]      a_reg, a_next;
    logic [cma_pkg::SUM_W-1:0]      b_reg, b_next;
    logic                           zero_reg, zero_next;
    logic [cma_pkg::SUM_W-1:0]      rem_reg, rem_next;
    logic [cma_pkg::FRAC_W-1:0]     quo_reg, quo_next;
    logic [cma_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [cma_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic [cma_pkg::SUM_W:0]        shifted;
    logic [cma_pkg::SUM_W:0]        diff;
    logic                           fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, b_reg};
    assign fits    = (shifted >= {1'b0, b_reg});

    always_comb
    begin
        dstate_next = dstate_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        zero_next   = zero_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        rate_next   = rate_reg;
        unique case (dstate_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    // Magnitudes as unsigned; the most negative sum maps to 2^55.
                    a_next    = incorrect_sum[cma_pkg::SUM_W-1] ?
                                (~incorrect_sum + 1'b1) : incorrect_sum;
                    b_next    = total_sum[cma_pkg::SUM_W-1] ?
                                (~total_sum + 1'b1) : total_sum;
                    zero_next = (incorrect_sum == '0) || (total_sum == '0) ||
                                (incorrect_sum[cma_pkg::SUM_W-1] !=
                                 total_sum[cma_pkg::SUM_W-1]);
                    dstate_next = D_CMP;
                end
            end
            D_CMP:
            begin
                if (zero_reg)
                begin
                    rate_next   = cma_pkg::RATE_ZERO;
                    done_next   = 1'b1;
                    dstate_next = D_IDLE;
                end
                else if (a_reg >= b_reg)
                begin
                    rate_next   = cma_pkg::RATE_ONE;
                    done_next   = 1'b1;
                    dstate_next = D_IDLE;
                end
                else
                begin
                    rem_next    = a_reg;
                    quo_next    = '0;
                    cnt_next    = '0;
                    dstate_next = D_STEP;
                end
            end
            D_STEP:
            begin
                // The remainder stays below the divisor, so it fits in SUM_W bits.
                rem_next = fits ? diff[cma_pkg::SUM_W-1:0] : shifted[cma_pkg::SUM_W-1:0];
                quo_next = {quo_reg[cma_pkg::FRAC_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cma_pkg::STEP_W'(cma_pkg::FRAC_W - 1))
                begin
                    rate_next   = {1'b0, quo_reg[cma_pkg::FRAC_W-2:0], fits};
                    done_next   = 1'b1;
                    dstate_next = D_IDLE;
                end
            end
            default:
            begin
                dstate_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            dstate_reg <= dstate_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        rate_reg <= rate_next;
    end

    assign done = done_reg;
    assign rate = rate_reg;

endmodule

/* rtl/confusion_matrix_accumulator.sv */
`timescale 1ns / 1ps
// Confusion matrix accumulator top level; depends on cma_pkg and cma_rate_div.
// Add: a cell read, a saturating add and write, then the response; a missing flag or a range
// error goes straight to the response. Query for n active classes: a cell a cycle over n*n cells,
// five combining adds and 16 divider steps, skipped when a sum is zero, the signs differ or the rate clamps to one.
// One transaction at a time, the next taken in the cycle after a response is loaded, even if it waits.
// Reset is asynchronous and active low: the table reads as zero and num_classes is 2.
module confusion_matrix_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  cma_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output cma_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cma_pkg::NCLS_W-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_ADD_WR = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_COMB   = 4'd5;
    localparam logic [3:0] S_DIVGO  = 4'd6;
    localparam logic [3:0] S_DIVW   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // Each cell lands in exactly one of five partial sums.
    localparam logic [2:0] CAT_TP  = 3'd0;
    localparam logic [2:0] CAT_FP  = 3'd1;
    localparam logic [2:0] CAT_FN  = 3'd2;
    localparam logic [2:0] CAT_TND = 3'd3;
    localparam logic [2:0] CAT_TNO = 3'd4;

    localparam int SW = cma_pkg::SUM_W;
    localparam int CW = cma_pkg::CELL_W;

    localparam logic signed [SW-1:0] CELL_MAX_S = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] CELL_MIN_S = -CELL_MAX_S - 1;

    logic [3:0]                          state_reg, state_next;
    cma_pkg::req_t                       item_reg;
    logic [cma_pkg::NCLS_W-1:0]          ncls_reg;
    logic [cma_pkg::NCLS_W-1:0]          n_act;
    logic [cma_pkg::CLASS_W-1:0]         n_last;

    logic [CW-1:0]                       cell_mem [cma_pkg::CELLS];
    logic [cma_pkg::CELLS-1:0]           cell_vld_reg;
    logic [CW-1:0]                       rd_data_reg;
    logic                                rd_vld_reg;
    logic [cma_pkg::ADDR_W-1:0]          rd_addr;
    logic [cma_pkg::ADDR_W-1:0]          wr_addr;
    logic                                mem_we;
    logic [CW-1:0]                       wr_data;
    logic signed [CW-1:0]                cell_val;

    logic [cma_pkg::CLASS_W-1:0]         row_reg, row_next;
    logic [cma_pkg::CLASS_W-1:0]         col_reg, col_next;
    logic                                p_vld_reg, p_vld_next;
    logic [2:0]                          p_cat_reg, p_cat_next;
    logic [2:0]                          step_reg, step_next;

    logic signed [SW-1:0]                tp_reg, fp_reg, fn_reg, tnd_reg, tno_reg;
    logic signed [SW-1:0]                tn_reg, cor_reg, inc_reg, tot_reg;
    logic [cma_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic                                full_reg, full_next;

    logic signed [SW-1:0]                op_a, op_b, sum;
    logic signed [SW-1:0]                sat_cell;

    logic                                rsp_valid_reg, rsp_valid_next;
    cma_pkg::rsp_t                       rsp_reg, rsp_next;
    logic                                out_free;

    logic                                div_start;
    logic                                div_done;
    logic [cma_pkg::RATE_W-1:0]          div_rate;

    logic                                add_bad_range;
    logic                                qry_bad_range;

    // Register values outside 2..MAX_CLASSES act as the nearest bound.
    assign n_act = (ncls_reg < cma_pkg::NCLS_MIN) ? cma_pkg::NCLS_MIN :
                   (ncls_reg > cma_pkg::NCLS_MAX) ? cma_pkg::NCLS_MAX : ncls_reg;
    assign n_last = cma_pkg::CLASS_W'(n_act - 1'b1);

    assign add_bad_range = ({1'b0, item_reg.actual_class} >= n_act) ||
                           ({1'b0, item_reg.predicted_class} >= n_act);
    assign qry_bad_range = ({1'b0, item_reg.query_class} >= n_act);

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign div_start = (state_reg == S_DIVGO);

    assign wr_addr  = {item_reg.actual_class, item_reg.predicted_class};
    assign rd_addr  = (state_reg == S_WALK) ? {row_reg, col_reg} : wr_addr;
    assign cell_val = rd_vld_reg ? rd_data_reg : '0;

    // Shared adder operand selection.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (p_vld_reg)
        begin
            op_b = SW'(cell_val);
            unique case (p_cat_reg)
                CAT_TP:  op_a = tp_reg;
                CAT_FP:  op_a = fp_reg;
                CAT_FN:  op_a = fn_reg;
                CAT_TND: op_a = tnd_reg;
                default: op_a = tno_reg;
            endcase
        end
        else if (state_reg == S_ADD_WR)
        begin
            op_a = SW'(cell_val);
            op_b = SW'(item_reg.weight);
        end
        else if (state_reg == S_COMB)
        begin
            unique case (step_reg)
                3'd0:
                begin
                    op_a = tnd_reg;
                    op_b = tno_reg;
                end
                3'd1:
                begin
                    op_a = tp_reg;
                    op_b = tnd_reg;
                end
                3'd2:
                begin
                    op_a = fp_reg;
                    op_b = fn_reg;
                end
                3'd3:
                begin
                    op_a = inc_reg;
                    op_b = tno_reg;
                end
                default:
                begin
                    op_a = cor_reg;
                    op_b = inc_reg;
                end
            endcase
        end
    end

    assign sum = op_a + op_b;

    always_comb
    begin
        if (sum > CELL_MAX_S)
        begin
            sat_cell = CELL_MAX_S;
        end
        else if (sum < CELL_MIN_S)
        begin
            sat_cell = CELL_MIN_S;
        end
        else
        begin
            sat_cell = sum;
        end
    end

    assign mem_we  = (state_reg == S_ADD_WR);
    assign wr_data = sat_cell[CW-1:0];

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        p_vld_next  = 1'b0;
        p_cat_next  = p_cat_reg;
        step_next   = step_reg;
        status_next = status_reg;
        full_next   = full_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                full_next = 1'b0;
                if (item_reg.action == cma_pkg::ACT_ADD)
                begin
                    // A missing predicted value is reported ahead of a missing actual.
                    priority if (item_reg.predicted_missing)
                    begin
                        status_next = cma_pkg::ST_PRED_MISSING;
                        state_next  = S_OUT;
                    end
                    else if (item_reg.actual_missing)
                    begin
                        status_next = cma_pkg::ST_ACT_MISSING;
                        state_next  = S_OUT;
                    end
                    else if (add_bad_range)
                    begin
                        status_next = cma_pkg::ST_RANGE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        status_next = cma_pkg::ST_OK;
                        state_next  = S_ADD_WR;
                    end
                end
                else if (qry_bad_range)
                begin
                    status_next = cma_pkg::ST_RANGE;
                    state_next  = S_OUT;
                end
                else
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_ADD_WR:
            begin
                state_next = S_OUT;
            end
            S_WALK:
            begin
                p_vld_next = 1'b1;
                priority if (row_reg == item_reg.query_class)
                begin
                    p_cat_next = (col_reg == item_reg.query_class) ? CAT_TP : CAT_FN;
                end
                else if (col_reg == item_reg.query_class)
                begin
                    p_cat_next = CAT_FP;
                end
                else
                begin
                    p_cat_next = (row_reg == col_reg) ? CAT_TND : CAT_TNO;
                end
                if (col_reg == n_last)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (row_reg == n_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                step_next  = '0;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                full_next   = 1'b1;
                status_next = (tot_reg == '0) ? cma_pkg::ST_ZERO_TOTAL : cma_pkg::ST_OK;
                state_next  = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if ((state_reg == S_OUT) && out_free)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next               = '0;
            rsp_next.status        = status_reg;
            if (full_reg)
            begin
                rsp_next.true_pos      = tp_reg;
                rsp_next.false_pos     = fp_reg;
                rsp_next.true_neg      = tn_reg;
                rsp_next.false_neg     = fn_reg;
                rsp_next.correct_sum   = cor_reg;
                rsp_next.incorrect_sum = inc_reg;
                rsp_next.total_sum     = tot_reg;
                rsp_next.error_rate    = div_rate;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ncls_reg      <= cma_pkg::NCLS_RESET;
            rsp_valid_reg <= 1'b0;
            p_vld_reg     <= 1'b0;
            step_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            status_reg    <= cma_pkg::ST_OK;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            p_vld_reg     <= p_vld_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            status_reg    <= status_next;
            full_reg      <= full_next;
            if (cfg_valid && cfg_ready)
            begin
                ncls_reg <= cfg_data;
            end
        end
    end

    // Cells never written read as zero through their valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= '0;
        end
        else if (mem_we)
        begin
            cell_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cell_mem[rd_addr];
        rd_vld_reg  <= cell_vld_reg[rd_addr];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        p_cat_reg <= p_cat_next;
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        if ((state_reg == S_CHECK) && (state_next == S_WALK))
        begin
            tp_reg  <= '0;
            fp_reg  <= '0;
            fn_reg  <= '0;
            tnd_reg <= '0;
            tno_reg <= '0;
        end
        else if (p_vld_reg)
        begin
            unique case (p_cat_reg)
                CAT_TP:  tp_reg  <= sum;
                CAT_FP:  fp_reg  <= sum;
                CAT_FN:  fn_reg  <= sum;
                CAT_TND: tnd_reg <= sum;
                default: tno_reg <= sum;
            endcase
        end
        if (state_reg == S_COMB)
        begin
            unique case (step_reg)
                3'd0:    tn_reg  <= sum;
                3'd1:    cor_reg <= sum;
                3'd2:    inc_reg <= sum;
                3'd3:    inc_reg <= sum;
                default: tot_reg <= sum;
            endcase
        end
    end

    cma_rate_div u_rate_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .incorrect_sum (inc_reg),
        .total_sum     (tot_reg),
        .done          (div_done),
        .rate          (div_rate)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
